// ===== sv/hcpw_pkg.sv =====
package hcpw_pkg;

  // Curve limits
  localparam int MAX_ORDER   = 6;
  localparam int MAX_SEGMENT = 256;

  // Field widths
  localparam int ORDER_W = $clog2(MAX_ORDER + 1);
  localparam int LVL_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int DIG_W   = 2 * MAX_ORDER;
  localparam int LEN_W   = 9;
  localparam int COORD_W = 10;
  localparam int COLOR_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_ORDER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR     = 3'd4;

  // Reset values of the registers
  localparam logic [ORDER_W-1:0] ORDER_RST  = ORDER_W'(1);
  localparam logic [LEN_W-1:0]   LENGTH_RST = LEN_W'(4);
  localparam logic [COLOR_W-1:0] COLOR_RST  = COLOR_W'(1);

  typedef logic [1:0] pat_t;
  typedef logic [1:0] move_t;

  // Curve patterns
  localparam pat_t PAT_A = 2'd0;
  localparam pat_t PAT_B = 2'd1;
  localparam pat_t PAT_C = 2'd2;
  localparam pat_t PAT_D = 2'd3;

  // Pen moves
  localparam move_t MV_LEFT  = 2'd0;
  localparam move_t MV_UP    = 2'd1;
  localparam move_t MV_RIGHT = 2'd2;
  localparam move_t MV_DOWN  = 2'd3;

  // Sub-pattern at a given digit of a pattern
  function automatic pat_t child_pat(input pat_t pat, input logic [1:0] dig);
    pat_t res;
    res = PAT_A;
    case ({pat, dig})
      {PAT_A, 2'd0}: res = PAT_D;
      {PAT_A, 2'd1}: res = PAT_A;
      {PAT_A, 2'd2}: res = PAT_A;
      {PAT_A, 2'd3}: res = PAT_B;
      {PAT_B, 2'd0}: res = PAT_C;
      {PAT_B, 2'd1}: res = PAT_B;
      {PAT_B, 2'd2}: res = PAT_B;
      {PAT_B, 2'd3}: res = PAT_A;
      {PAT_C, 2'd0}: res = PAT_B;
      {PAT_C, 2'd1}: res = PAT_C;
      {PAT_C, 2'd2}: res = PAT_C;
      {PAT_C, 2'd3}: res = PAT_D;
      {PAT_D, 2'd0}: res = PAT_A;
      {PAT_D, 2'd1}: res = PAT_D;
      {PAT_D, 2'd2}: res = PAT_D;
      default:       res = PAT_C;
    endcase
    return res;
  endfunction

  // Connecting move after a given digit of a pattern (digit 0..2)
  function automatic move_t move_dir(input pat_t pat, input logic [1:0] dig);
    move_t res;
    res = MV_LEFT;
    case ({pat, dig})
      {PAT_A, 2'd0}: res = MV_LEFT;
      {PAT_A, 2'd1}: res = MV_UP;
      {PAT_A, 2'd2}: res = MV_RIGHT;
      {PAT_B, 2'd0}: res = MV_DOWN;
      {PAT_B, 2'd1}: res = MV_RIGHT;
      {PAT_B, 2'd2}: res = MV_UP;
      {PAT_C, 2'd0}: res = MV_RIGHT;
      {PAT_C, 2'd1}: res = MV_DOWN;
      {PAT_C, 2'd2}: res = MV_LEFT;
      {PAT_D, 2'd0}: res = MV_UP;
      {PAT_D, 2'd1}: res = MV_LEFT;
      {PAT_D, 2'd2}: res = MV_DOWN;
      default:       res = MV_LEFT;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/hilbert_curve_pixel_walker.sv =====
// Hilbert curve pixel walker. Every input beat gives exactly one output beat,
// in the cycle after it is taken, and a new beat is taken every clock while the
// output side is not stalled: the rate is one pixel per clock, set by the
// update of the segment digit counter and the six-level pattern decode that
// picks the pen move. A beat with in_restart high loads the pen from
// start_x/start_y, latches curve_order and segment_length and gives a beat
// with pixel_valid 0; further beats each step the pen by one pixel. The last
// pixel of the curve carries is_last, and beats after it give pixel_valid 0
// until the next restart. The result sits in an output register; in_stall is
// high while that register holds a beat the consumer has not taken.
module hilbert_curve_pixel_walker (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [hcpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hcpw_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_restart,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hcpw_pkg::COORD_W-1:0]    out_pixel_x,
  output logic [hcpw_pkg::COORD_W-1:0]    out_pixel_y,
  output logic [hcpw_pkg::COLOR_W-1:0]    out_pixel_color,
  output logic                            out_pixel_valid,
  output logic                            out_is_last
);
  import hcpw_pkg::*;

  // configuration registers
  logic [ORDER_W-1:0] curve_order_r;
  logic [LEN_W-1:0]   segment_length_r;
  logic [COORD_W-1:0] start_x_r;
  logic [COORD_W-1:0] start_y_r;
  logic [COLOR_W-1:0] draw_color_r;

  // walk state
  logic [DIG_W-1:0]   seg_r;
  logic [LEN_W-1:0]   step_r;
  logic [COORD_W-1:0] pos_x_r;
  logic [COORD_W-1:0] pos_y_r;
  logic               done_r;
  logic [ORDER_W-1:0] run_order_r;
  logic [LEN_W-1:0]   run_len_r;

  // output register
  logic               out_valid_r;
  logic [COORD_W-1:0] out_x_r;
  logic [COORD_W-1:0] out_y_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_pv_r;
  logic               out_last_r;

  // next-state values
  logic [DIG_W-1:0]   seg_nxt;
  logic [LEN_W-1:0]   step_nxt;
  logic [COORD_W-1:0] pos_x_nxt;
  logic [COORD_W-1:0] pos_y_nxt;
  logic               done_nxt;
  logic [ORDER_W-1:0] run_order_nxt;
  logic [LEN_W-1:0]   run_len_nxt;
  logic               last_nxt;
  logic               pv_nxt;

  logic               in_acc;
  logic [LVL_W-1:0]   lvl;
  logic               found;
  pat_t               pat;
  logic [1:0]         dig;
  move_t              mv;
  logic [DIG_W-1:0]   seg_mask;
  logic [DIG_W-1:0]   seg_inc;
  logic [LEN_W-1:0]   step_inc;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_order_r    <= ORDER_RST;
      segment_length_r <= LENGTH_RST;
      start_x_r        <= '0;
      start_y_r        <= '0;
      draw_color_r     <= COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CURVE_ORDER:    curve_order_r    <= cfg_wdata[ORDER_W-1:0];
        REG_SEGMENT_LENGTH: segment_length_r <= cfg_wdata[LEN_W-1:0];
        REG_START_X:        start_x_r        <= cfg_wdata[COORD_W-1:0];
        REG_START_Y:        start_y_r        <= cfg_wdata[COORD_W-1:0];
        REG_DRAW_COLOR:     draw_color_r     <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // lowest level whose digit is not three picks the connecting move
  always_comb begin
    lvl   = LVL_W'(run_order_r - ORDER_W'(1));
    found = 1'b0;
    for (int k = 0; k < MAX_ORDER - 1; k++) begin
      if (!found && (ORDER_W'(k + 1) < run_order_r) && (seg_r[2*k +: 2] != 2'd3)) begin
        lvl   = LVL_W'(k);
        found = 1'b1;
      end
    end
  end

  // descend the pattern tree from the top level down to just above lvl
  always_comb begin
    pat = PAT_A;
    for (int k = MAX_ORDER - 1; k >= 0; k--) begin
      if ((ORDER_W'(k) < run_order_r) && (LVL_W'(k) > lvl)) begin
        pat = child_pat(pat, seg_r[2*k +: 2]);
      end
    end
    dig = seg_r[{lvl, 1'b0} +: 2];
    if (dig == 2'd3) begin
      dig = 2'd2;
    end
    mv = move_dir(pat, dig);
  end

  // digits in use for the latched order
  always_comb begin
    for (int k = 0; k < MAX_ORDER; k++) begin
      seg_mask[2*k +: 2] = (ORDER_W'(k) < run_order_r) ? 2'b11 : 2'b00;
    end
  end

  assign seg_inc  = seg_r + DIG_W'(1);
  assign step_inc = step_r + LEN_W'(1);

  // next walk state and result
  always_comb begin
    seg_nxt       = seg_r;
    step_nxt      = step_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    done_nxt      = done_r;
    run_order_nxt = run_order_r;
    run_len_nxt   = run_len_r;
    last_nxt      = 1'b0;
    pv_nxt        = 1'b0;
    if (in_restart) begin
      seg_nxt   = '0;
      step_nxt  = '0;
      pos_x_nxt = start_x_r;
      pos_y_nxt = start_y_r;
      done_nxt  = 1'b0;
      if (curve_order_r == '0) begin
        run_order_nxt = ORDER_W'(1);
      end else if (curve_order_r > ORDER_W'(MAX_ORDER)) begin
        run_order_nxt = ORDER_W'(MAX_ORDER);
      end else begin
        run_order_nxt = curve_order_r;
      end
      if (segment_length_r == '0) begin
        run_len_nxt = LEN_W'(1);
      end else if (segment_length_r > LEN_W'(MAX_SEGMENT)) begin
        run_len_nxt = LEN_W'(MAX_SEGMENT);
      end else begin
        run_len_nxt = segment_length_r;
      end
    end else if (!done_r) begin
      pv_nxt = 1'b1;
      case (mv)
        MV_LEFT:  pos_x_nxt = pos_x_r - COORD_W'(1);
        MV_RIGHT: pos_x_nxt = pos_x_r + COORD_W'(1);
        MV_UP:    pos_y_nxt = pos_y_r - COORD_W'(1);
        default:  pos_y_nxt = pos_y_r + COORD_W'(1);
      endcase
      if (step_inc >= run_len_r) begin
        step_nxt = '0;
        seg_nxt  = seg_inc;
        if ((seg_inc & seg_mask) == seg_mask) begin
          last_nxt = 1'b1;
          done_nxt = 1'b1;
        end
      end else begin
        step_nxt = step_inc;
      end
    end
  end

  // walk state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= '0;
      step_r      <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      done_r      <= 1'b1;
      run_order_r <= ORDER_RST;
      run_len_r   <= LENGTH_RST;
    end else if (in_acc) begin
      seg_r       <= seg_nxt;
      step_r      <= step_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      done_r      <= done_nxt;
      run_order_r <= run_order_nxt;
      run_len_r   <= run_len_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_x_r     <= pv_nxt ? pos_x_nxt : '0;
      out_y_r     <= pv_nxt ? pos_y_nxt : '0;
      out_color_r <= pv_nxt ? draw_color_r : '0;
      out_pv_r    <= pv_nxt;
      out_last_r  <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_x_r;
  assign out_pixel_y     = out_y_r;
  assign out_pixel_color = out_color_r;
  assign out_pixel_valid = out_pv_r;
  assign out_is_last     = out_last_r;

  // checks
  a_done_step_clear: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (step_r == '0))
    else $error("walk idle with a partial segment");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < run_len_r)
    else $error("step count reached the segment length");

  a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
    (run_order_r != '0) && (run_order_r <= ORDER_W'(MAX_ORDER)))
    else $error("latched order out of range");

  a_unused_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (seg_r & ~seg_mask) == '0)
    else $error("digit set above the curve order");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_pv_r)
    else $error("last flag on a beat without a pixel");

endmodule
